FILE: src/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same clock edge
`define NPS_ASSERT_NOW(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// implication checked at the next clock edge
`define NPS_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

FILE: src/nps_pkg.sv
// shared constants and control types for the priority scheduler
`default_nettype none

package nps_pkg;

    localparam int MAX_PROCS   = 16;
    localparam int RESULT_CAP  = 16;
    localparam int TABLE_CAP   = (MAX_PROCS < RESULT_CAP) ? MAX_PROCS : RESULT_CAP;
    localparam int IDX_W       = (TABLE_CAP > 1) ? $clog2(TABLE_CAP) : 1;
    localparam int COUNT_W     = $clog2(TABLE_CAP + 1);

    localparam int ARRIVAL_W   = 16;
    localparam int BURST_W     = 16;
    localparam int PRIO_W      = 8;
    localparam int JOB_INDEX_W = 4;
    localparam int TIME_W      = 21;
    localparam int SUM_W       = 25;

    typedef struct packed {
        logic load;
        logic start_set;
        logic scan_step;
        logic jump;
        logic calc;
        logic emit;
        logic finish;
    } nps_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic found;
        logic out_free;
        logic last_round;
    } nps_status_t;

endpackage

`default_nettype wire

FILE: src/nps_ctrl.sv
// controller state machine for the priority scheduler
`default_nettype none

module nps_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  logic               last_job,
    input  nps_pkg::nps_status_t status,
    output logic               job_stall,
    output nps_pkg::nps_cmd_t  cmd
);
    import nps_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_CALC   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        job_stall  = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    cmd.load = 1'b1;
                    if (last_job)
                    begin
                        cmd.start_set = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.found)
                begin
                    state_next = ST_CALC;
                end
                else
                begin
                    // nothing has arrived yet: move time forward and rescan
                    cmd.jump   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_round)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/nps_datapath.sv
// job table, selection scan, time arithmetic and result register
`default_nettype none

module nps_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nps_pkg::nps_cmd_t                    cmd,
    output nps_pkg::nps_status_t                 status,
    input  logic [nps_pkg::ARRIVAL_W-1:0]        arrival,
    input  logic [nps_pkg::BURST_W-1:0]          burst,
    input  logic [nps_pkg::PRIO_W-1:0]           prio,
    input  logic                                 result_stall,
    output logic                                 result_valid,
    output logic [nps_pkg::JOB_INDEX_W-1:0]      job_index,
    output logic [nps_pkg::TIME_W-1:0]           start_at,
    output logic [nps_pkg::TIME_W-1:0]           finish_at,
    output logic [nps_pkg::TIME_W-1:0]           turnaround,
    output logic [nps_pkg::TIME_W-1:0]           waiting,
    output logic [nps_pkg::TIME_W-1:0]           response,
    output logic [nps_pkg::SUM_W-1:0]            sum_waiting,
    output logic [nps_pkg::SUM_W-1:0]            sum_turnaround,
    output logic [nps_pkg::SUM_W-1:0]            sum_response,
    output logic                                 last_result
);
    import nps_pkg::*;

    // job table
    logic [ARRIVAL_W-1:0] arr_tab [TABLE_CAP];
    logic [BURST_W-1:0]   burst_tab [TABLE_CAP];
    logic [PRIO_W-1:0]    prio_tab [TABLE_CAP];
    logic [TABLE_CAP-1:0] done_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   round_reg;

    // scan state
    logic [IDX_W-1:0]     scan_idx_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_idx_reg;
    logic [PRIO_W-1:0]    pick_prio_reg;
    logic [ARRIVAL_W-1:0] pick_arr_reg;
    logic [BURST_W-1:0]   pick_burst_reg;
    logic [ARRIVAL_W-1:0] earliest_reg;

    // time and per-job values
    logic [TIME_W-1:0]    clock_reg;
    logic [TIME_W-1:0]    start_reg;
    logic [TIME_W-1:0]    rt_reg;
    logic [TIME_W-1:0]    tat_reg;
    logic [SUM_W-1:0]     acc_w_reg;
    logic [SUM_W-1:0]     acc_t_reg;
    logic [SUM_W-1:0]     acc_r_reg;

    logic                 result_valid_reg;

    logic [ARRIVAL_W-1:0] cur_arr;
    logic [PRIO_W-1:0]    cur_prio;
    logic [BURST_W-1:0]   cur_burst;
    logic                 cur_pending;
    logic                 cur_ready;
    logic                 cur_better;
    logic                 scan_init;
    logic                 table_open;
    logic [TIME_W-1:0]    pick_arr_ext;
    logic [TIME_W-1:0]    pick_burst_ext;
    logic [TIME_W-1:0]    rt_next;
    logic [TIME_W-1:0]    tat_next;
    logic [TIME_W-1:0]    fin_next;
    logic [SUM_W-1:0]     acc_w_next;
    logic [SUM_W-1:0]     acc_t_next;
    logic [SUM_W-1:0]     acc_r_next;

    assign cur_arr     = arr_tab[scan_idx_reg];
    assign cur_prio    = prio_tab[scan_idx_reg];
    assign cur_burst   = burst_tab[scan_idx_reg];
    assign cur_pending = !done_reg[scan_idx_reg];
    assign cur_ready   = cur_pending && (TIME_W'(cur_arr) <= clock_reg);
    // strict compares keep the lower index on a full tie
    assign cur_better  = !found_reg || (cur_prio < pick_prio_reg) ||
                         ((cur_prio == pick_prio_reg) && (cur_arr < pick_arr_reg));
    assign scan_init   = cmd.start_set || cmd.jump || cmd.emit;
    assign table_open  = (count_reg < COUNT_W'(TABLE_CAP));

    assign pick_arr_ext   = TIME_W'(pick_arr_reg);
    assign pick_burst_ext = TIME_W'(pick_burst_reg);
    assign rt_next        = clock_reg - pick_arr_ext;
    assign tat_next       = rt_next + pick_burst_ext;
    assign fin_next       = clock_reg + pick_burst_ext;
    assign acc_w_next     = acc_w_reg + SUM_W'(rt_reg);
    assign acc_t_next     = acc_t_reg + SUM_W'(tat_reg);
    assign acc_r_next     = acc_r_reg + SUM_W'(rt_reg);

    assign status.scan_last  = ((COUNT_W'(scan_idx_reg) + COUNT_W'(1)) == count_reg);
    assign status.found      = found_reg;
    assign status.out_free   = !result_valid_reg || !result_stall;
    assign status.last_round = (round_reg == count_reg);

    assign result_valid = result_valid_reg;

    // table payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load && table_open)
        begin
            arr_tab[count_reg[IDX_W-1:0]]   <= arrival;
            burst_tab[count_reg[IDX_W-1:0]] <= burst;
            prio_tab[count_reg[IDX_W-1:0]]  <= prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= '0;
            round_reg <= '0;
        end
        else
        begin
            if (cmd.finish)
            begin
                count_reg <= '0;
                done_reg  <= '0;
            end
            else
            begin
                if (cmd.load && table_open)
                begin
                    count_reg <= count_reg + COUNT_W'(1);
                end
                if (cmd.calc)
                begin
                    done_reg[pick_idx_reg] <= 1'b1;
                end
            end
            if (cmd.start_set)
            begin
                round_reg <= '0;
            end
            else if (cmd.calc)
            begin
                round_reg <= round_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            if (scan_init)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                if (cur_ready && cur_better)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // best candidate and earliest pending arrival, gathered in one pass
    always_ff @(posedge clk)
    begin
        if (scan_init)
        begin
            earliest_reg <= '1;
        end
        else if (cmd.scan_step)
        begin
            if (cur_ready && cur_better)
            begin
                pick_idx_reg   <= scan_idx_reg;
                pick_prio_reg  <= cur_prio;
                pick_arr_reg   <= cur_arr;
                pick_burst_reg <= cur_burst;
            end
            if (cur_pending && (cur_arr < earliest_reg))
            begin
                earliest_reg <= cur_arr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_set)
        begin
            clock_reg <= '0;
            acc_w_reg <= '0;
            acc_t_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (cmd.jump)
        begin
            clock_reg <= TIME_W'(earliest_reg);
        end
        else if (cmd.calc)
        begin
            start_reg <= clock_reg;
            rt_reg    <= rt_next;
            tat_reg   <= tat_next;
            clock_reg <= fin_next;
        end
        else if (cmd.emit)
        begin
            acc_w_reg <= acc_w_next;
            acc_t_reg <= acc_t_next;
            acc_r_reg <= acc_r_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            job_index      <= JOB_INDEX_W'(pick_idx_reg);
            start_at       <= start_reg;
            finish_at      <= clock_reg;
            turnaround     <= tat_reg;
            waiting        <= rt_reg;
            response       <= rt_reg;
            sum_waiting    <= acc_w_next;
            sum_turnaround <= acc_t_next;
            sum_response   <= acc_r_next;
            last_result    <= status.last_round;
        end
    end

endmodule

`default_nettype wire

FILE: src/nonpreemptive_priority_scheduler_core.sv
// Nonpreemptive priority scheduler. Jobs (arrival, burst, prio) load one per cycle into
// a table of up to 16 entries; the job flagged last_job closes the set and starts the
// schedule. Each round scans the table one entry per cycle for the arrived, unfinished
// job with the lowest prio (ties: earlier arrival, then lower index), runs it to
// completion and emits one result with its times and running sums; the final result
// carries last_result. Each round is a scan of the table over the single read port, then
// select, compute and emit, with a further scan and select whenever time has to jump to
// the next pending arrival. job_stall stays high from the last job until the final
// result is in the output register.
`default_nettype none

module nonpreemptive_priority_scheduler_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 job_valid,
    output logic                                 job_stall,
    input  logic [nps_pkg::ARRIVAL_W-1:0]        arrival,
    input  logic [nps_pkg::BURST_W-1:0]          burst,
    input  logic [nps_pkg::PRIO_W-1:0]           prio,
    input  logic                                 last_job,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [nps_pkg::JOB_INDEX_W-1:0]      job_index,
    output logic [nps_pkg::TIME_W-1:0]           start_at,
    output logic [nps_pkg::TIME_W-1:0]           finish_at,
    output logic [nps_pkg::TIME_W-1:0]           turnaround,
    output logic [nps_pkg::TIME_W-1:0]           waiting,
    output logic [nps_pkg::TIME_W-1:0]           response,
    output logic [nps_pkg::SUM_W-1:0]            sum_waiting,
    output logic [nps_pkg::SUM_W-1:0]            sum_turnaround,
    output logic [nps_pkg::SUM_W-1:0]            sum_response,
    output logic                                 last_result
);
    import nps_pkg::*;

    nps_cmd_t    cmd;
    nps_status_t status;

    nps_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .last_job  (last_job),
        .status    (status),
        .job_stall (job_stall),
        .cmd       (cmd)
    );

    nps_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .arrival        (arrival),
        .burst          (burst),
        .prio           (prio),
        .result_stall   (result_stall),
        .result_valid   (result_valid),
        .job_index      (job_index),
        .start_at       (start_at),
        .finish_at      (finish_at),
        .turnaround     (turnaround),
        .waiting        (waiting),
        .response       (response),
        .sum_waiting    (sum_waiting),
        .sum_turnaround (sum_turnaround),
        .sum_response   (sum_response),
        .last_result    (last_result)
    );

endmodule

`default_nettype wire

FILE: src/nps_checker.sv
// port-level checks for the scheduler core and their bind
`default_nettype none
`include "assert_macros.svh"

module nps_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 job_valid,
    input logic                                 job_stall,
    input logic                                 last_job,
    input logic                                 result_valid,
    input logic                                 result_stall,
    input logic                                 last_result
);

    // a stalled result request stays offered
    `NPS_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid,
        "result request dropped while stalled")

    // closing a set makes the block busy
    `NPS_ASSERT_NEXT(a_busy_after_last, job_valid && !job_stall && last_job, job_stall,
        "job port open right after the last job of a set")

    // no new result right after the final one is taken
    `NPS_ASSERT_NEXT(a_quiet_after_final, result_valid && !result_stall && last_result,
        !result_valid, "result follows the final result of a set")

    // while a non-final result of a set is offered no job is taken
    `NPS_ASSERT_NOW(a_busy_mid_set, result_valid && !last_result, job_stall,
        "job port open before the final result of a set")

endmodule

bind nonpreemptive_priority_scheduler_core nps_checker u_nps_checker (.*);

`default_nettype wire

FILE: tb/nps_schedule_checker.sv
// watches both channels of the scheduler, predicts each schedule and compares the results
`timescale 1ns / 1ps

module nps_schedule_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               job_valid,
    input  logic                               job_stall,
    input  logic [nps_pkg::ARRIVAL_W-1:0]      arrival,
    input  logic [nps_pkg::BURST_W-1:0]        burst,
    input  logic [nps_pkg::PRIO_W-1:0]         prio,
    input  logic                               last_job,
    input  logic                               result_valid,
    input  logic                               result_stall,
    input  logic [nps_pkg::JOB_INDEX_W-1:0]    job_index,
    input  logic [nps_pkg::TIME_W-1:0]         start_at,
    input  logic [nps_pkg::TIME_W-1:0]         finish_at,
    input  logic [nps_pkg::TIME_W-1:0]         turnaround,
    input  logic [nps_pkg::TIME_W-1:0]         waiting,
    input  logic [nps_pkg::TIME_W-1:0]         response,
    input  logic [nps_pkg::SUM_W-1:0]          sum_waiting,
    input  logic [nps_pkg::SUM_W-1:0]          sum_turnaround,
    input  logic [nps_pkg::SUM_W-1:0]          sum_response,
    input  logic                               last_result,
    output int unsigned                        fail_count,
    output int unsigned                        results_owed
);

    import nps_pkg::*;

    typedef struct packed {
        logic [JOB_INDEX_W-1:0] job_index;
        logic [TIME_W-1:0]      start_at;
        logic [TIME_W-1:0]      finish_at;
        logic [TIME_W-1:0]      turnaround;
        logic [TIME_W-1:0]      waiting;
        logic [TIME_W-1:0]      response;
        logic [SUM_W-1:0]       sum_waiting;
        logic [SUM_W-1:0]       sum_turnaround;
        logic [SUM_W-1:0]       sum_response;
        logic                   last_result;
    } job_outcome_t;

    logic [ARRIVAL_W-1:0] set_arrival [TABLE_CAP];
    logic [BURST_W-1:0]   set_burst [TABLE_CAP];
    logic [PRIO_W-1:0]    set_prio [TABLE_CAP];
    int                   set_size;
    job_outcome_t         outcome_queue [$];

    // runs the loaded set to completion and queues one outcome per job
    function automatic void plan_schedule();
        bit           ran [TABLE_CAP];
        longint       now;
        longint       fin;
        longint       tat;
        longint       wt;
        longint       rt;
        longint       sw;
        longint       st;
        longint       sr;
        longint       earliest;
        int           pick;
        int           rounds;
        job_outcome_t res;
        for (int i = 0; i < TABLE_CAP; i++)
            ran[i] = 1'b0;
        now = 0;
        sw = 0;
        st = 0;
        sr = 0;
        rounds = 0;
        while (rounds < set_size)
        begin
            pick = -1;
            for (int i = 0; i < set_size; i++)
            begin
                if (!ran[i] && set_arrival[i] <= now)
                begin
                    if (pick < 0 || set_prio[i] < set_prio[pick] ||
                        (set_prio[i] == set_prio[pick] && set_arrival[i] < set_arrival[pick]))
                        pick = i;
                end
            end
            if (pick < 0)
            begin
                // idle cpu: jump ahead to the next pending arrival
                earliest = 64'hFFFF_FFFF;
                for (int i = 0; i < set_size; i++)
                    if (!ran[i] && set_arrival[i] < earliest)
                        earliest = set_arrival[i];
                now = earliest;
            end
            else
            begin
                fin = now + set_burst[pick];
                tat = fin - set_arrival[pick];
                wt = tat - set_burst[pick];
                rt = now - set_arrival[pick];
                sw += wt;
                st += tat;
                sr += rt;
                res.job_index = JOB_INDEX_W'(pick);
                res.start_at = TIME_W'(now);
                res.finish_at = TIME_W'(fin);
                res.turnaround = TIME_W'(tat);
                res.waiting = TIME_W'(wt);
                res.response = TIME_W'(rt);
                res.sum_waiting = SUM_W'(sw);
                res.sum_turnaround = SUM_W'(st);
                res.sum_response = SUM_W'(sr);
                res.last_result = (rounds + 1 == set_size);
                outcome_queue.push_back(res);
                ran[pick] = 1'b1;
                now = fin & 64'h1F_FFFF;
                rounds++;
            end
        end
    endfunction

    function automatic void take_job();
        // a full table drops the job, but its last mark still closes the set
        if (set_size < TABLE_CAP)
        begin
            set_arrival[set_size] = arrival;
            set_burst[set_size] = burst;
            set_prio[set_size] = prio;
            set_size++;
        end
        if (last_job)
        begin
            plan_schedule();
            set_size = 0;
        end
    endfunction

    function automatic void compare_field(string label, logic [SUM_W-1:0] want,
                                          logic [SUM_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", label, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result();
        job_outcome_t want;
        if (outcome_queue.size() == 0)
        begin
            $error("job_index: expected no result, actual %0d", job_index);
            fail_count++;
        end
        else
        begin
            want = outcome_queue.pop_front();
            compare_field("job_index", SUM_W'(want.job_index), SUM_W'(job_index));
            compare_field("start_at", SUM_W'(want.start_at), SUM_W'(start_at));
            compare_field("finish_at", SUM_W'(want.finish_at), SUM_W'(finish_at));
            compare_field("turnaround", SUM_W'(want.turnaround), SUM_W'(turnaround));
            compare_field("waiting", SUM_W'(want.waiting), SUM_W'(waiting));
            compare_field("response", SUM_W'(want.response), SUM_W'(response));
            compare_field("sum_waiting", want.sum_waiting, sum_waiting);
            compare_field("sum_turnaround", want.sum_turnaround, sum_turnaround);
            compare_field("sum_response", want.sum_response, sum_response);
            compare_field("last_result", SUM_W'(want.last_result), SUM_W'(last_result));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size = 0;
            outcome_queue.delete();
            fail_count = 0;
            results_owed = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result();
            if (job_valid && !job_stall)
                take_job();
            results_owed = outcome_queue.size();
        end
    end

endmodule

FILE: tb/nonpreemptive_priority_scheduler_core_tb.sv
// drives job requests into the priority scheduler and gives the verdict
`timescale 1ns / 1ps

module nonpreemptive_priority_scheduler_core_tb;

    import nps_pkg::*;

    localparam int ITEM_TARGET = 280;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 600;

    logic                   clk;
    logic                   rst_n;
    logic                   job_valid;
    logic                   job_stall;
    logic [ARRIVAL_W-1:0]   arrival;
    logic [BURST_W-1:0]     burst;
    logic [PRIO_W-1:0]      prio;
    logic                   last_job;
    logic                   result_valid;
    logic                   result_stall;
    logic [JOB_INDEX_W-1:0] job_index;
    logic [TIME_W-1:0]      start_at;
    logic [TIME_W-1:0]      finish_at;
    logic [TIME_W-1:0]      turnaround;
    logic [TIME_W-1:0]      waiting;
    logic [TIME_W-1:0]      response;
    logic [SUM_W-1:0]       sum_waiting;
    logic [SUM_W-1:0]       sum_turnaround;
    logic [SUM_W-1:0]       sum_response;
    logic                   last_result;

    int unsigned            fail_count;
    int unsigned            results_owed;
    int unsigned            cycle_count = 0;
    int                     items_sent;
    logic                   no_idle;
    logic                   pressure_go;

    nonpreemptive_priority_scheduler_core u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (job_valid),
        .job_stall      (job_stall),
        .arrival        (arrival),
        .burst          (burst),
        .prio           (prio),
        .last_job       (last_job),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .job_index      (job_index),
        .start_at       (start_at),
        .finish_at      (finish_at),
        .turnaround     (turnaround),
        .waiting        (waiting),
        .response       (response),
        .sum_waiting    (sum_waiting),
        .sum_turnaround (sum_turnaround),
        .sum_response   (sum_response),
        .last_result    (last_result)
    );

    nps_schedule_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (job_valid),
        .job_stall      (job_stall),
        .arrival        (arrival),
        .burst          (burst),
        .prio           (prio),
        .last_job       (last_job),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .job_index      (job_index),
        .start_at       (start_at),
        .finish_at      (finish_at),
        .turnaround     (turnaround),
        .waiting        (waiting),
        .response       (response),
        .sum_waiting    (sum_waiting),
        .sum_turnaround (sum_turnaround),
        .sum_response   (sum_response),
        .last_result    (last_result),
        .fail_count     (fail_count),
        .results_owed   (results_owed)
    );

    initial
        clk = 1'b0;

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("nonpreemptive_priority_scheduler_core_tb failed");
            $finish;
        end
    end

    // entered and left just after a falling edge
    task automatic send_job(input logic [ARRIVAL_W-1:0] arr, input logic [BURST_W-1:0] bst,
                            input logic [PRIO_W-1:0] pri, input logic closes_set);
        while (!no_idle && $urandom_range(0, 99) < 8)
        begin
            job_valid <= 1'b0;
            @(negedge clk);
        end
        job_valid <= 1'b1;
        arrival <= arr;
        burst <= bst;
        prio <= pri;
        last_job <= closes_set;
        @(posedge clk);
        while (job_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // result side: random stalls, one long hold-off, and a quiet stretch
    initial
    begin
        int hold_left;
        bit hold_done;
        result_stall = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (pressure_go && !hold_done)
            begin
                result_stall <= 1'b1;
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
            end
            else if (no_idle)
                result_stall <= 1'b0;
            else
                result_stall <= ($urandom_range(0, 99) < 8);
        end
    end

    initial
    begin
        int                   set_len;
        int                   style;
        logic [ARRIVAL_W-1:0] a;
        logic [BURST_W-1:0]   b;
        logic [PRIO_W-1:0]    p;
        items_sent = 0;
        no_idle = 1'b0;
        pressure_go = 1'b0;
        job_valid = 1'b0;
        arrival = '0;
        burst = '0;
        prio = '0;
        last_job = 1'b0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // lone job, all fields zero, zero burst
        send_job('0, '0, '0, 1'b1);
        // nothing has arrived at time zero, so the clock jumps twice; equal jobs go by index
        send_job('1, '1, '1, 1'b0);
        send_job('1, '1, '1, 1'b0);
        send_job(ARRIVAL_W'(10), BURST_W'(5), '1, 1'b1);
        // priority wins first, then the earlier arrival breaks a tie
        send_job('0, BURST_W'(40), PRIO_W'(9), 1'b0);
        send_job(ARRIVAL_W'(3), BURST_W'(2), PRIO_W'(1), 1'b0);
        send_job(ARRIVAL_W'(2), BURST_W'(2), PRIO_W'(1), 1'b0);
        send_job(ARRIVAL_W'(1), '0, '0, 1'b1);
        // overfull table: the extra job is dropped but its last mark runs the set
        for (int i = 0; i <= TABLE_CAP; i++)
            send_job('1, '1, PRIO_W'($urandom_range(0, 255)), i == TABLE_CAP);

        while (items_sent < ITEM_TARGET)
        begin
            no_idle = (items_sent >= 120 && items_sent < 180);
            if (items_sent >= 60)
                pressure_go = 1'b1;
            if ($urandom_range(0, 99) < 8)
                set_len = $urandom_range(TABLE_CAP, TABLE_CAP + 4);
            else
                set_len = $urandom_range(1, 6);
            style = $urandom_range(0, 3);
            for (int i = 0; i < set_len; i++)
            begin
                if (style == 0)
                begin
                    a = ARRIVAL_W'($urandom_range(0, 65535));
                    b = BURST_W'($urandom_range(0, 65535));
                    p = PRIO_W'($urandom_range(0, 255));
                end
                else
                begin
                    // tight values so jobs overlap and priorities collide
                    a = ARRIVAL_W'($urandom_range(0, 40));
                    b = BURST_W'($urandom_range(0, 20));
                    p = PRIO_W'($urandom_range(0, 3));
                end
                send_job(a, b, p, i == set_len - 1);
            end
        end
        job_valid <= 1'b0;

        while (results_owed != 0)
            @(negedge clk);
        repeat (64) @(negedge clk);
        if (fail_count == 0 && results_owed == 0)
            $display("nonpreemptive_priority_scheduler_core_tb passed");
        else
            $display("nonpreemptive_priority_scheduler_core_tb failed");
        $finish;
    end

endmodule

FILE: nonpreemptive_priority_scheduler_core.f
+incdir+src
src/nps_pkg.sv
src/nps_ctrl.sv
src/nps_datapath.sv
src/nonpreemptive_priority_scheduler_core.sv
src/nps_checker.sv
tb/nps_schedule_checker.sv
tb/nonpreemptive_priority_scheduler_core_tb.sv
